[rtl/sjpq_pkg.sv]
// ----------------------------------------------------------------------------
// sjpq_pkg
// Shared constants and types for the sorted job priority queue.
// ----------------------------------------------------------------------------
package sjpq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

  localparam logic       REQ_INSERT = 1'b0;
  localparam logic       REQ_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] size;
    logic [15:0]         pid;
  } slot_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

[rtl/sjpq_if.sv]
// ----------------------------------------------------------------------------
// sjpq_req_if / sjpq_rsp_if
// Valid/ready channels for requests and results of the job queue.
// ----------------------------------------------------------------------------
interface sjpq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] job_len;
  logic [15:0] proc_tag;

  modport source (output valid, req_type, job_len, proc_tag, input ready);
  modport sink   (input valid, req_type, job_len, proc_tag, output ready);
endinterface

interface sjpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_job_size;
  logic [15:0] out_process_id;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  modport source (output valid, out_job_size, out_process_id, status, entry_count,
                  input ready);
  modport sink   (input valid, out_job_size, out_process_id, status, entry_count,
                  output ready);
endinterface

[rtl/sjpq_cell.sv]
// ----------------------------------------------------------------------------
// sjpq_cell
// One slot of the sorted chain: keep, take the new job, or shift from a neighbour.
// ----------------------------------------------------------------------------
module sjpq_cell
  import sjpq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       prev_lt_i,
  input  slot_t      new_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  output slot_t      slot_o,
  output logic       lt_o
);

  slot_t slot_q, slot_d;

  assign lt_o   = occ_i && (slot_q.size < new_i.size);
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.pop) begin
      slot_d = right_i;
    end else if (ctrl_i.insert && !lt_o) begin
      slot_d = prev_lt_i ? new_i : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[rtl/sorted_job_priority_queue_core.sv]
// Result: an accepted request's result is registered and held until taken.
// Throughput: one request per cycle while no result waits untaken; every
// cell compares and shifts in the cycle of acceptance, so the rate is set by
// the chain update. Reset: entry count and result valid clear at once; slots
// hold no reset value and are read only below the entry count.
// ----------------------------------------------------------------------------
// sorted_job_priority_queue_core
// Shortest-job-first queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
module sorted_job_priority_queue_core
  import sjpq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sjpq_req_if.sink          req,
  sjpq_rsp_if.source        rsp
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_valid_q;
  logic [15:0]      rsp_size_q;
  logic [15:0]      rsp_pid_q;
  logic [1:0]       rsp_status_q;
  logic [CNT_W-1:0] rsp_count_q;

  logic       accept, full, empty, do_ins, do_pop;
  cell_ctrl_t ctrl;
  slot_t      new_slot;
  slot_t      slots [DEPTH];
  logic       lt    [DEPTH];

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign do_ins    = accept && (req.req_type == REQ_INSERT) && !full;
  assign do_pop    = accept && (req.req_type == REQ_POP) && !empty;

  assign ctrl.insert   = do_ins;
  assign ctrl.pop      = do_pop;
  assign new_slot.size = KEY_BITS'(req.job_len);
  assign new_slot.pid  = req.proc_tag;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sjpq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (count_q > CNT_W'(i)),
      .prev_lt_i ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
      .new_i     (new_slot),
      .left_i    (slots[(i == 0) ? 0 : i - 1]),
      .right_i   (slots[(i == DEPTH - 1) ? i : i + 1]),
      .slot_o    (slots[i]),
      .lt_o      (lt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_size_q  <= do_pop ? 16'(slots[0].size) : 16'd0;
      rsp_pid_q   <= do_pop ? slots[0].pid : 16'd0;
      rsp_count_q <= count_d;
      if (req.req_type == REQ_POP) begin
        rsp_status_q <= empty ? STATUS_EMPTY : STATUS_OK;
      end else begin
        rsp_status_q <= full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.out_job_size   = rsp_size_q;
  assign rsp.out_process_id = rsp_pid_q;
  assign rsp.status         = rsp_status_q;
  assign rsp.entry_count    = 5'(rsp_count_q);

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count moved without a transaction");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.req_type == REQ_POP && empty) |=>
      (rsp_status_q == STATUS_EMPTY && rsp_count_q == '0))
    else $error("pop on empty queue not reported");

  a_ins_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.req_type == REQ_INSERT && full) |=>
      (rsp_status_q == STATUS_FULL && count_q == CNT_W'(DEPTH)))
    else $error("insert into full queue not dropped");
`endif

endmodule

[tb/sjpq_checker.sv]
// ----------------------------------------------------------------------------
// sjpq_checker
// Watches the request and result channels of the job queue, keeps its own
// sorted copy of the stored jobs and checks every result transaction against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sjpq_checker
  import sjpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sjpq_req_if         req,
  sjpq_rsp_if         rsp,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [15:0] job_len;
    logic [15:0] proc_tag;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } job_result_t;

  slot_t       job_slots [DEPTH];
  int          job_count = 0;
  job_result_t queued_results [$];
  int unsigned mismatches = 0;

  assign error_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] sjpq mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic job_result_t predict_request(input logic        kind,
                                                  input logic [15:0] size_in,
                                                  input logic [15:0] pid_in);
    job_result_t         res;
    logic [KEY_BITS-1:0] key;
    int                  pos;
    res = '0;
    key = size_in[KEY_BITS-1:0];
    pos = 0;
    res.status = STATUS_OK;
    if (kind == REQ_INSERT) begin
      if (job_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        for (int i = 0; i < job_count; i++) begin
          if (job_slots[i].size < key) pos++;
        end
        for (int i = job_count; i > pos; i--) begin
          job_slots[i] = job_slots[i-1];
        end
        job_slots[pos].size = key;
        job_slots[pos].pid  = pid_in;
        job_count++;
      end
    end else if (job_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.job_len  = 16'(job_slots[0].size);
      res.proc_tag = job_slots[0].pid;
      for (int i = 1; i < job_count; i++) begin
        job_slots[i-1] = job_slots[i];
      end
      job_count--;
    end
    res.entry_count = 5'(job_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    job_result_t got;
    job_result_t want;
    if (!rst_ni) begin
      queued_results.delete();
      job_count = 0;
      pending_o <= 0;
    end else begin
      if (req.valid && req.ready) begin
        queued_results.push_back(predict_request(req.req_type, req.job_len,
                                                 req.proc_tag));
      end
      if (rsp.valid && rsp.ready) begin
        got.job_len     = rsp.out_job_size;
        got.proc_tag    = rsp.out_process_id;
        got.status      = rsp.status;
        got.entry_count = rsp.entry_count;
        if (queued_results.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: %h", got));
        end else begin
          want = queued_results.pop_front();
          if (got.job_len !== want.job_len)
            report_mismatch($sformatf("out_job_size got %h want %h",
                                      got.job_len, want.job_len));
          if (got.proc_tag !== want.proc_tag)
            report_mismatch($sformatf("out_process_id got %h want %h",
                                      got.proc_tag, want.proc_tag));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %h want %h",
                                      got.status, want.status));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        end
      end
      pending_o <= queued_results.size();
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the shortest-job-first queue: a directed opening on
// empty, full and equal-size cases, then random phases that swing the fill
// level between empty and full, with bursty requests, receiver stalls, a long
// result hold-off and full drains. The checker alongside does the prediction.
// ----------------------------------------------------------------------------
module tb_top
  import sjpq_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_PERIODIC,
    RDY_SPARSE
  } stall_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned error_count;
  int unsigned pending;
  int unsigned cycle_count  = 0;
  int unsigned hold_requests = 0;
  int unsigned burst_left    = 0;
  int unsigned items_sent    = 0;

  sjpq_req_if req_ch ();
  sjpq_rsp_if rsp_ch ();

  sorted_job_priority_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  sjpq_checker queue_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_job_priority_queue_core verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_size();
    logic [15:0] sz;
    case ($urandom_range(0, 9))
      0:       sz = 16'h0000;
      1:       sz = 16'hFFFF;
      2, 3, 4: sz = 16'($urandom_range(0, 7));
      default: sz = 16'($urandom_range(0, 65535));
    endcase
    return sz;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the transaction.
  task automatic drive_req(input logic kind, input logic [15:0] sz,
                           input logic [15:0] pid);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.job_len  <= sz;
    req_ch.proc_tag <= pid;
    do @(posedge clk_i); while (!req_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : rsp_stall
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned holds_served;
    mode         = RDY_ALWAYS;
    mode_left    = 0;
    holds_served = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS:   rsp_ch.ready <= 1'b1;
          RDY_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RDY_PERIODIC: rsp_ch.ready <= ((mode_left % 4) != 0);
          default:      rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned insert_pct;
    int unsigned phase_len;
    logic        kind;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.job_len  <= '0;
    req_ch.proc_tag <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    drive_req(REQ_POP, 16'hFFFF, 16'hFFFF);
    drive_req(REQ_INSERT, 16'h0000, 16'h0000);
    drive_req(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    drive_req(REQ_INSERT, 16'h1234, 16'hAAAA);
    drive_req(REQ_INSERT, 16'h1234, 16'h5555);
    repeat (5) drive_req(REQ_POP, 16'h0000, 16'h0000);
    for (int i = 0; i < DEPTH; i++) begin
      drive_req(REQ_INSERT, 16'(DEPTH - i), 16'(i * 4099));
    end
    drive_req(REQ_INSERT, 16'h8000, 16'h8000);
    drive_req(REQ_POP, 16'h5A5A, 16'hA5A5);

    // hold off results while requests keep coming, then drain fully
    wait_drained();
    hold_requests <= hold_requests + 1;
    repeat (12) drive_req(REQ_INSERT, pick_size(), 16'($urandom_range(0, 65535)));
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        2:       insert_pct = 85;
        default: insert_pct = 97;
      endcase
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 9))
        0:       wait_drained();
        1:       hold_requests <= hold_requests + 1;
        default: ;
      endcase
      repeat (phase_len) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
        drive_req(kind, pick_size(), 16'($urandom_range(0, 65535)));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("sorted_job_priority_queue_core verification clean");
    end else begin
      $display("sorted_job_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule
